// ===== rtl/conv3x3_divide_clamp_rgb_assert.svh =====
// Assertion macro used by c3f_back.
`ifndef CONV3X3_DIVIDE_CLAMP_RGB_ASSERT_SVH
`define CONV3X3_DIVIDE_CLAMP_RGB_ASSERT_SVH
// Check an implication at every rising clock edge outside reset.
`define C3_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`endif

// ===== rtl/c3f_pkg.sv =====
// ----------------------------------------------------------------------------
// c3f_pkg: types and constants of the 3x3 RGB convolution filter
// Beat payloads, register indexes, reset values, the front-to-back record and back states.
// ----------------------------------------------------------------------------
package c3f_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int COEF_BITS_DEF  = 16;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 48;
    localparam int SUM_BITS       = 16;
    localparam int DIV_BITS       = 15;
    localparam int GEOM_BITS      = 11;
    localparam int COORD_BITS     = 10;

    localparam logic [CFG_IDX_BITS-1:0] REG_KROW0  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_KROW1  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_KROW2  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIVISOR = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 3'd5;

    localparam logic [47:0] KROW1_RESET = 48'd65536;
    localparam logic [7:0]  PIX_MAX     = 8'd255;

    typedef struct packed {
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
    } t_in_beat;

    typedef struct packed {
        logic       frame_last;
        logic [9:0] out_col;
        logic [9:0] out_row;
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
    } t_out_beat;

    // one complete window handed from front to back
    typedef struct packed {
        logic [8:0][23:0] win;
        logic [9:0]       row;
        logic [9:0]       col;
        logic             last;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE, ST_MAC, ST_DIV, ST_OUT
    } t_back_state;
endpackage

// ===== rtl/c3f_front.sv =====
// ----------------------------------------------------------------------------
// c3f_front: line buffers, 3x3 window and raster counters
// Accepts pixels, keeps the window and issues a job for each interior pixel.
// ----------------------------------------------------------------------------
module c3f_front #(
    parameter int MAX_WIDTH  = c3f_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = c3f_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  c3f_pkg::t_in_beat                   i_data,
    input  logic [c3f_pkg::GEOM_BITS-1:0]       i_width,
    input  logic [c3f_pkg::GEOM_BITS-1:0]       i_height,
    output logic                                o_job_valid,
    input  logic                                i_job_full,
    output c3f_pkg::t_job                       o_job
);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH);

    // stage 0: accept and read line buffers; stage 1: update window
    logic [23:0] r_upper [MAX_WIDTH];
    logic [23:0] r_middle [MAX_WIDTH];
    logic [23:0] r_mid_rd, r_pix;
    logic        r_s1_valid, r_s1_emit, r_s1_last;
    logic [9:0]  r_s1_row, r_s1_col;
    logic [AW-1:0] r_s1_addr;
    logic [8:0][23:0] r_win, n_win;
    logic        r_job_valid;
    logic [9:0]  r_job_row, r_job_col;
    logic        r_job_last;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] w_lim;
    logic [RW-1:0] h_lim;
    logic [AW-1:0] c_addr;
    logic        acc, hazard;
    logic [23:0] up_v, mid_v;
    logic [23:0] r_up_raw;
    logic        r_fwd;
    logic [23:0] r_mid_prev, r_pix_prev;

    always_comb begin
        if (i_width < 11'd3) w_lim = CW'(3);
        else if (32'(i_width) > MAX_WIDTH) w_lim = CW'(MAX_WIDTH);
        else w_lim = CW'(i_width);
        if (i_height < 11'd3) h_lim = RW'(3);
        else if (32'(i_height) > MAX_HEIGHT) h_lim = RW'(MAX_HEIGHT);
        else h_lim = RW'(i_height);
    end

    // hold input while a job forms in stage 1 or waits in the job register
    assign o_stall = r_job_valid || (r_s1_valid && r_s1_emit);
    assign acc     = i_valid && !o_stall;
    assign c_addr  = r_col[AW-1:0];
    // forward the write if the same column comes back to back (widths below 3 are raised to 3)
    assign hazard  = r_s1_valid && (r_s1_addr == c_addr);

    always_comb begin
        n_col = r_col + CW'(1);
        n_row = r_row;
        if (n_col >= w_lim) begin
            n_col = '0;
            n_row = r_row + RW'(1);
            if (n_row >= h_lim) n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_mid_rd <= r_middle[c_addr];
            r_pix    <= i_data;
            r_s1_addr <= c_addr;
            r_s1_row <= 10'(r_row - RW'(1));
            r_s1_col <= 10'(c_addr - AW'(1));
            r_s1_emit <= (r_row >= RW'(2)) && (c_addr >= AW'(2));
            r_s1_last <= (r_row == h_lim - RW'(1)) && (32'(c_addr) == 32'(w_lim) - 1);
        end
    end
    // upper read goes in its own block so each memory has one read port
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_up_raw <= r_upper[c_addr];
            r_fwd    <= hazard;
        end
    end

    assign up_v  = r_fwd ? r_mid_prev : r_up_raw;
    assign mid_v = r_fwd ? r_pix_prev : r_mid_rd;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_upper[r_s1_addr]  <= mid_v;
            r_middle[r_s1_addr] <= r_pix;
            r_mid_prev <= mid_v;
            r_pix_prev <= r_pix;
        end
    end

    always_comb begin
        n_win = r_win;
        for (int i = 0; i < 3; i++) begin
            n_win[i*3+0] = r_win[i*3+1];
            n_win[i*3+1] = r_win[i*3+2];
        end
        n_win[2] = up_v;
        n_win[5] = mid_v;
        n_win[8] = r_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_s1_valid <= 1'b0;
            r_job_valid <= 1'b0;
            r_win <= '0;
        end else begin
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_s1_valid <= acc;
            if (r_job_valid && !i_job_full) r_job_valid <= 1'b0;
            if (r_s1_valid) begin
                r_win <= n_win;
                if (r_s1_emit) r_job_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_emit) begin
            r_job_row  <= r_s1_row;
            r_job_col  <= r_s1_col;
            r_job_last <= r_s1_last;
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job.win   = r_win;
    assign o_job.row   = r_job_row;
    assign o_job.col   = r_job_col;
    assign o_job.last  = r_job_last;
endmodule

// ===== rtl/c3f_queue.sv =====
// ----------------------------------------------------------------------------
// c3f_queue: short job queue between front and back
// Four-entry register FIFO with full and empty flags.
// ----------------------------------------------------------------------------
module c3f_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  c3f_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output c3f_pkg::t_job o_job
);
    c3f_pkg::t_job r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       push_ok, pop_ok;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) r_wp <= r_wp + 2'd1;
            if (pop_ok) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push_ok) - 3'(pop_ok);
        end
    end
endmodule

// ===== rtl/c3f_back.sv =====
// ----------------------------------------------------------------------------
// c3f_back: multiply-accumulate, divide and clamp
// One tap a cycle into three 16-bit sums, then a restoring divider.
// ----------------------------------------------------------------------------
`include "conv3x3_divide_clamp_rgb_assert.svh"
module c3f_back #(
    parameter int COEF_BITS = c3f_pkg::COEF_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  c3f_pkg::t_job         i_job,
    output logic                  o_pop,
    input  logic [47:0]           i_krow0,
    input  logic [47:0]           i_krow1,
    input  logic [47:0]           i_krow2,
    input  logic [14:0]           i_divisor,
    output logic                  o_valid,
    input  logic                  i_stall,
    output c3f_pkg::t_out_beat    o_data
);
    c3f_pkg::t_back_state r_state, n_state;
    c3f_pkg::t_job r_job;
    logic [3:0]  r_tap;
    logic [3:0]  r_step;
    logic [2:0][15:0] r_acc;
    logic [2:0][15:0] r_mag;
    logic [2:0][14:0] r_rem;
    logic [2:0]       r_neg;
    logic [14:0] d;
    logic [15:0] coef;
    logic [47:0] krow;
    logic [1:0]  trow, tcol;
    logic        r_valid;
    c3f_pkg::t_out_beat r_out;
    logic load, mac_done, div_done;

    function automatic logic [7:0] clampq(input logic neg, input logic [15:0] q);
        if (neg || q == 16'd0) return 8'd0;
        if (q > 16'd255) return c3f_pkg::PIX_MAX;
        return q[7:0];
    endfunction

    assign d = (i_divisor == 15'd0) ? 15'd1 : i_divisor;

    always_comb begin
        // tap index to kernel row and column
        case (r_tap)
            4'd0:    begin trow = 2'd0; tcol = 2'd0; end
            4'd1:    begin trow = 2'd0; tcol = 2'd1; end
            4'd2:    begin trow = 2'd0; tcol = 2'd2; end
            4'd3:    begin trow = 2'd1; tcol = 2'd0; end
            4'd4:    begin trow = 2'd1; tcol = 2'd1; end
            4'd5:    begin trow = 2'd1; tcol = 2'd2; end
            4'd6:    begin trow = 2'd2; tcol = 2'd0; end
            4'd7:    begin trow = 2'd2; tcol = 2'd1; end
            default: begin trow = 2'd2; tcol = 2'd2; end
        endcase
        case (trow)
            2'd0:    krow = i_krow0;
            2'd1:    krow = i_krow1;
            default: krow = i_krow2;
        endcase
        coef = 16'(signed'(krow[16*tcol +: COEF_BITS]));
    end

    assign load     = (r_state == c3f_pkg::ST_IDLE) && !i_empty;
    assign mac_done = (r_state == c3f_pkg::ST_MAC) && (r_tap == 4'd8);
    assign div_done = (r_state == c3f_pkg::ST_DIV) && (r_step == 4'd15);

    always_comb begin
        n_state = r_state;
        case (r_state)
            c3f_pkg::ST_IDLE: if (!i_empty) n_state = c3f_pkg::ST_MAC;
            c3f_pkg::ST_MAC:  if (mac_done) n_state = c3f_pkg::ST_DIV;
            c3f_pkg::ST_DIV:  if (div_done) n_state = c3f_pkg::ST_OUT;
            c3f_pkg::ST_OUT:  if (!r_valid || !i_stall) n_state = c3f_pkg::ST_IDLE;
            default:          n_state = c3f_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop = load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= c3f_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_valid && !i_stall) r_valid <= 1'b0;
            if (r_state == c3f_pkg::ST_OUT && (!r_valid || !i_stall)) r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [15:0] rr;
        logic [15:0] trial;
        if (load) begin
            r_job <= i_job;
            r_tap <= '0;
            r_acc <= '0;
        end
        if (r_state == c3f_pkg::ST_MAC) begin
            for (int p = 0; p < 3; p++)
                r_acc[p] <= r_acc[p] + 16'({8'd0, r_job.win[r_tap][8*p +: 8]} * coef);
            r_tap <= r_tap + 4'd1;
            if (mac_done) begin
                r_step <= '0;
                for (int p = 0; p < 3; p++) begin
                    logic [15:0] s;
                    s = r_acc[p] + 16'({8'd0, r_job.win[r_tap][8*p +: 8]} * coef);
                    r_neg[p] <= s[15];
                    r_mag[p] <= s[15] ? 16'(-s) : s;
                    r_rem[p] <= '0;
                end
            end
        end
        if (r_state == c3f_pkg::ST_DIV) begin
            // one quotient bit per cycle, MSB first; quotient replaces dividend
            for (int p = 0; p < 3; p++) begin
                rr = {r_rem[p], r_mag[p][15]};
                trial = rr - {1'b0, d};
                if (!trial[15]) begin
                    r_rem[p] <= trial[14:0];
                    r_mag[p] <= {r_mag[p][14:0], 1'b1};
                end else begin
                    r_rem[p] <= rr[14:0];
                    r_mag[p] <= {r_mag[p][14:0], 1'b0};
                end
            end
            r_step <= r_step + 4'd1;
        end
        if (r_state == c3f_pkg::ST_OUT && (!r_valid || !i_stall)) begin
            r_out.out_row <= r_job.row;
            r_out.out_col <= r_job.col;
            r_out.frame_last <= r_job.last;
            r_out.red_out   <= clampq(r_neg[0], r_mag[0]);
            r_out.green_out <= clampq(r_neg[1], r_mag[1]);
            r_out.blue_out  <= clampq(r_neg[2], r_mag[2]);
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

    `C3_ASSERT(a_pop_idle, i_clk, i_rst_n, o_pop |-> !i_empty, "pop from empty queue")
    `C3_ASSERT(a_mac_len, i_clk, i_rst_n, mac_done |=> r_state == c3f_pkg::ST_DIV,
        "mac did not hand to divider")
    `C3_ASSERT(a_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_data)),
        "result changed while stalled")
endmodule

// ===== rtl/conv3x3_divide_clamp_rgb.sv =====
// Path from accepted pixel to result valid: 2 front stages, 1 queue entry, 1 load,
// 9 MAC taps, 16 divide steps and the output state.
// Results are paced by the shared MAC/divide unit, which loads a job only when idle; a 4-job
// queue decouples. Border pixels enter one per cycle unless the front stalls the input.
// Reset: synchronous active low; clears counters, window, queue and registers.
// Line buffers are not cleared.
// ----------------------------------------------------------------------------
// conv3x3_divide_clamp_rgb: 3x3 RGB convolution, divide and clamp
// Front keeps the window, a queue carries jobs, the back computes results.
// ----------------------------------------------------------------------------
module conv3x3_divide_clamp_rgb #(
    parameter int MAX_WIDTH  = c3f_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = c3f_pkg::MAX_HEIGHT_DEF,
    parameter int COEF_BITS  = c3f_pkg::COEF_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  c3f_pkg::t_in_beat                     i_data,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output c3f_pkg::t_out_beat                    o_data,
    input  logic                                  i_cfg_we,
    input  logic [c3f_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [c3f_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    logic [47:0] r_k0, r_k1, r_k2;
    logic [14:0] r_div;
    logic [10:0] r_w, r_h;
    logic job_valid, q_full, q_empty, pop;
    c3f_pkg::t_job job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k0 <= '0;
            r_k1 <= c3f_pkg::KROW1_RESET;
            r_k2 <= '0;
            r_div <= 15'd1;
            r_w <= 11'd1024;
            r_h <= 11'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                c3f_pkg::REG_KROW0:   r_k0 <= i_cfg_data;
                c3f_pkg::REG_KROW1:   r_k1 <= i_cfg_data;
                c3f_pkg::REG_KROW2:   r_k2 <= i_cfg_data;
                c3f_pkg::REG_DIVISOR: r_div <= i_cfg_data[14:0];
                c3f_pkg::REG_WIDTH:   r_w <= i_cfg_data[10:0];
                c3f_pkg::REG_HEIGHT:  r_h <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    c3f_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .i_width(r_w), .i_height(r_h),
        .o_job_valid(job_valid), .i_job_full(q_full), .o_job(job_in)
    );

    c3f_queue u_queue (
        .i_clk, .i_rst_n, .i_push(job_valid), .i_job(job_in), .o_full(q_full),
        .i_pop(pop), .o_empty(q_empty), .o_job(job_out)
    );

    c3f_back #(.COEF_BITS(COEF_BITS)) u_back (
        .i_clk, .i_rst_n, .i_empty(q_empty), .i_job(job_out), .o_pop(pop),
        .i_krow0(r_k0), .i_krow1(r_k1), .i_krow2(r_k2), .i_divisor(r_div),
        .o_valid, .i_stall, .o_data
    );
endmodule

// ===== test/conv3x3_divide_clamp_rgb_test.sv =====
// ----------------------------------------------------------------------------
// conv3x3_divide_clamp_rgb_test: self-checking bench for the 3x3 RGB filter
// A directed table of pixels and register writes comes first. A smallest frame
// from out-of-range sizes follows, then random frames under several idle and
// stall patterns. A local model of the filter predicts every interior pixel,
// and each output beat is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module conv3x3_divide_clamp_rgb_test;
    localparam logic [c3f_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
    localparam int LINE_MAX    = 1024;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASE_ITEMS = 340;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct {
        bit                                  is_cfg;
        logic [c3f_pkg::CFG_IDX_BITS-1:0]    idx;
        logic [c3f_pkg::CFG_DATA_BITS-1:0]   data;
        c3f_pkg::t_in_beat                   px;
        bit                                  typed;
        c3f_pkg::t_out_beat                  want;
    } t_plan_row;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                i_stall = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [c3f_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx = '0;
    logic [c3f_pkg::CFG_DATA_BITS-1:0]   i_cfg_data = '0;
    c3f_pkg::t_in_beat                   i_data = '0;
    logic                                o_stall;
    logic                                o_valid;
    c3f_pkg::t_out_beat                  o_data;

    // filter model state
    logic [47:0]  krow [3];
    logic [14:0]  div_reg;
    logic [10:0]  width_reg;
    logic [10:0]  height_reg;
    logic [23:0]  upper_mem [LINE_MAX];
    logic [23:0]  middle_mem [LINE_MAX];
    logic [23:0]  win [9];
    int           col_pos;
    int           row_pos;

    c3f_pkg::t_out_beat filtered_q [$];
    t_plan_row    plan [$];
    int           errors = 0;
    int           cycles = 0;
    t_idle_mode   idle_mode = IDLE_NONE;
    bit           hold_req = 1'b0;
    bit           hold_taken;
    int           hold_left;

    conv3x3_divide_clamp_rgb DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int geom_lim(logic [10:0] v);
        if (v < 3) return 3;
        if (v > LINE_MAX) return LINE_MAX;
        return int'(v);
    endfunction

    task automatic filter_pixel(input c3f_pkg::t_in_beat px, output bit made,
                                output c3f_pkg::t_out_beat res);
        int          w;
        int          h;
        int          c;
        int          r;
        int          d;
        int          v;
        int          kern [9];
        logic [15:0] acc;
        logic [7:0]  chan [3];
        w = geom_lim(width_reg);
        h = geom_lim(height_reg);
        c = col_pos % LINE_MAX;
        r = row_pos;
        for (int i = 0; i < 3; i++) begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = upper_mem[c];
        win[5] = middle_mem[c];
        win[8] = px;
        upper_mem[c]  = middle_mem[c];
        middle_mem[c] = px;
        made = 1'b0;
        res = '0;
        if (r >= 2 && c >= 2) begin
            d = (div_reg == 0) ? 1 : int'(div_reg);
            for (int rr = 0; rr < 3; rr++)
                for (int j = 0; j < 3; j++)
                    kern[rr*3+j] = int'($signed(krow[rr][16*j +: 16]));
            for (int p = 0; p < 3; p++) begin
                acc = '0;
                for (int j = 0; j < 9; j++)
                    acc += 16'(int'(win[j][8*p +: 8]) * kern[j]);
                // truncating divide, then clamp to a pixel
                v = int'($signed(acc)) / d;
                if (v > 255) v = 255;
                if (v < 0) v = 0;
                chan[p] = 8'(v);
            end
            res.red_out    = chan[0];
            res.green_out  = chan[1];
            res.blue_out   = chan[2];
            res.out_row    = 10'(r - 1);
            res.out_col    = 10'(c - 1);
            res.frame_last = (r == h - 1) && (c == w - 1);
            made = 1'b1;
        end
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    // leaves the enable high; the caller drops it after its last write
    task automatic write_reg(logic [c3f_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [c3f_pkg::CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            c3f_pkg::REG_KROW0:   krow[0] = data;
            c3f_pkg::REG_KROW1:   krow[1] = data;
            c3f_pkg::REG_KROW2:   krow[2] = data;
            c3f_pkg::REG_DIVISOR: div_reg = data[14:0];
            c3f_pkg::REG_WIDTH:   width_reg = data[10:0];
            c3f_pkg::REG_HEIGHT:  height_reg = data[10:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_frame(logic [10:0] w, logic [10:0] h, logic [47:0] k0,
                             logic [47:0] k1, logic [47:0] k2, logic [14:0] dv);
        wait_idle();
        write_reg(c3f_pkg::REG_WIDTH, 48'(w));
        write_reg(c3f_pkg::REG_HEIGHT, 48'(h));
        write_reg(c3f_pkg::REG_KROW0, k0);
        write_reg(c3f_pkg::REG_KROW1, k1);
        write_reg(c3f_pkg::REG_KROW2, k2);
        write_reg(c3f_pkg::REG_DIVISOR, 48'(dv));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(c3f_pkg::t_in_beat px, output bit made,
                              output c3f_pkg::t_out_beat res);
        i_valid <= 1'b1;
        i_data  <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        filter_pixel(px, made, res);
    endtask

    task automatic sender_gap();
        bit dropped;
        dropped = 1'b0;
        if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
            while ($urandom_range(0, 99) < (idle_mode == IDLE_SEND ? 74 : 6)) begin
                if (!dropped) i_valid <= 1'b0;
                dropped = 1'b1;
                @(posedge i_clk);
            end
        end
    endtask

    task automatic run_frame();
        int                 n;
        bit                 made;
        c3f_pkg::t_out_beat res;
        n = geom_lim(width_reg) * geom_lim(height_reg);
        for (int k = 0; k < n; k++) begin
            send_pixel(c3f_pkg::t_in_beat'(24'($urandom)), made, res);
            if (made) filtered_q.push_back(res);
            sender_gap();
        end
        i_valid <= 1'b0;
    endtask

    function automatic logic [47:0] rand_krow(bit narrow);
        logic [47:0] k;
        if (!narrow) return {16'($urandom), 32'($urandom)};
        for (int j = 0; j < 3; j++)
            k[16*j +: 16] = 16'($signed($urandom_range(0, 8)) - 4);
        return k;
    endfunction

    task automatic random_frame(bit extreme_geom, logic [10:0] w, logic [10:0] h);
        bit narrow;
        narrow = $urandom_range(0, 9) < 7;
        if (!extreme_geom) begin
            w = ($urandom_range(0, 11) == 0) ? 11'($urandom_range(0, 2))
                                              : 11'($urandom_range(3, 12));
            h = ($urandom_range(0, 11) == 0) ? 11'($urandom_range(0, 2))
                                              : 11'($urandom_range(3, 9));
        end
        set_frame(w, h, rand_krow(narrow), rand_krow(narrow), rand_krow(narrow),
                  narrow ? 15'($urandom_range(1, 16)) : 15'($urandom_range(0, 32767)));
        run_frame();
    endtask

    task automatic plan_cfg(logic [c3f_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [c3f_pkg::CFG_DATA_BITS-1:0] data);
        t_plan_row row;
        row = '{1'b1, idx, data, '0, 1'b0, '0};
        plan.push_back(row);
    endtask

    task automatic plan_pix(c3f_pkg::t_in_beat px, bit typed = 1'b0,
                            c3f_pkg::t_out_beat want = '0);
        t_plan_row row;
        row = '{1'b0, REG_UNUSED, '0, px, typed, want};
        plan.push_back(row);
    endtask

    // receiver: random stall, plus one long hold to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            i_stall    <= 1'b1;
        end else if (idle_mode == IDLE_RECV) begin
            i_stall <= $urandom_range(0, 99) < 74;
        end else if (idle_mode == IDLE_BOTH) begin
            i_stall <= $urandom_range(0, 99) < 6;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        c3f_pkg::t_out_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (filtered_q.size() == 0) begin
                $display("%0t: unexpected beat: expected none, got %h", $time, o_data);
                errors++;
            end else begin
                want = filtered_q.pop_front();
                check_field("red_out", want.red_out, o_data.red_out);
                check_field("green_out", want.green_out, o_data.green_out);
                check_field("blue_out", want.blue_out, o_data.blue_out);
                check_field("out_row", want.out_row, o_data.out_row);
                check_field("out_col", want.out_col, o_data.out_col);
                check_field("frame_last", want.frame_last, o_data.frame_last);
            end
        end
    end

    initial begin
        bit                 made;
        c3f_pkg::t_out_beat res;
        krow[0] = '0;
        krow[1] = c3f_pkg::KROW1_RESET;
        krow[2] = '0;
        div_reg = 15'd1;
        width_reg = 11'd1024;
        height_reg = 11'd1024;
        foreach (win[i]) win[i] = '0;
        col_pos = 0;
        row_pos = 0;

        // identity kernel after reset: the center pixel comes back unchanged
        plan_cfg(c3f_pkg::REG_WIDTH, 48'd3);
        plan_cfg(c3f_pkg::REG_HEIGHT, 48'd3);
        plan_pix(24'h123456);
        plan_pix(24'h000000);
        plan_pix(24'hFFFFFF);
        plan_pix(24'h0A0B0C);
        plan_pix(24'h8000FF);
        plan_pix(24'h7F7F7F);
        plan_pix(24'h010203);
        plan_pix(24'hFEFDFC);
        plan_pix(24'h55AA55, 1'b1, '{1'b1, 10'd1, 10'd1, 8'h80, 8'h00, 8'hFF});
        // unknown index must be ignored
        plan_cfg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
        // largest coefficients on white with a zero divisor: saturates high
        plan_cfg(c3f_pkg::REG_KROW0, 48'h7FFF_7FFF_7FFF);
        plan_cfg(c3f_pkg::REG_KROW1, 48'h7FFF_7FFF_7FFF);
        plan_cfg(c3f_pkg::REG_KROW2, 48'h7FFF_7FFF_7FFF);
        plan_cfg(c3f_pkg::REG_DIVISOR, 48'd0);
        for (int k = 0; k < 8; k++) plan_pix(24'hFFFFFF);
        plan_pix(24'hFFFFFF, 1'b1, '{1'b1, 10'd1, 10'd1, 8'hFF, 8'hFF, 8'hFF});
        // most negative coefficients, largest divisor
        plan_cfg(c3f_pkg::REG_KROW0, 48'h8000_8000_8000);
        plan_cfg(c3f_pkg::REG_KROW1, 48'h8000_8000_8000);
        plan_cfg(c3f_pkg::REG_KROW2, 48'h8000_8000_8000);
        plan_cfg(c3f_pkg::REG_DIVISOR, 48'd32767);
        for (int k = 0; k < 9; k++)
            plan_pix(c3f_pkg::t_in_beat'(24'(24'h010101 * (k * 29))));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            if (plan[n].is_cfg) begin
                i_valid <= 1'b0;
                wait_idle();
                write_reg(plan[n].idx, plan[n].data);
                i_cfg_we <= 1'b0;
            end else begin
                send_pixel(plan[n].px, made, res);
                if (made) filtered_q.push_back(plan[n].typed ? plan[n].want : res);
                sender_gap();
            end
        end
        i_valid <= 1'b0;

        // smallest frame, from out-of-range low register values
        random_frame(1'b1, 11'd2, 11'd0);

        for (int ph = 0; ph < 4; ph++) begin
            int done;
            idle_mode = t_idle_mode'(ph);
            done = 0;
            if (idle_mode == IDLE_NONE) hold_req <= 1'b1;
            while (done < PHASE_ITEMS) begin
                random_frame(1'b0, '0, '0);
                done += geom_lim(width_reg) * geom_lim(height_reg);
            end
        end

        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/c3f_pkg.sv
rtl/c3f_front.sv
rtl/c3f_queue.sv
rtl/c3f_back.sv
rtl/conv3x3_divide_clamp_rgb.sv
test/conv3x3_divide_clamp_rgb_test.sv
